// ----- sv/pida_pkg.sv -----
// Shared types and codes for the positional insert/delete array.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pida_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR   = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_DISPLAY = 3'd2,
        CMD_INSERT  = 3'd3,
        CMD_DELETE  = 3'd4
    } cmd_code_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;
    localparam logic [1:0] STATUS_EMPTY = 2'd3;

    localparam int ElemWidth  = 32;
    localparam int FieldWidth = 5;

    typedef enum logic [1:0] {
        DP_NONE,
        DP_EXEC,
        DP_DISP_STEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic disp_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- sv/pida_ctrl.sv -----
// Controller for the positional insert/delete array: accepts items and
// sequences display runs. Depends on pida_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pida_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [2:0]        command,
    input  wire pida_pkg::dp_stat_t stat,
    output pida_pkg::dp_cmd_t      cmd
);
    import pida_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DISPLAY
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd.op     = DP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.op = DP_EXEC;
                    if (command == CMD_DISPLAY && !stat.count_zero) begin
                        state_next = ST_DISPLAY;
                    end
                end
            end
            ST_DISPLAY: begin
                if (stat.out_free) begin
                    cmd.op = DP_DISP_STEP;
                    if (stat.disp_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pida_dpath.sv -----
// Datapath for the positional insert/delete array: element cells, count,
// display index and the result register. Depends on pida_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pida_dpath #(
    parameter int DEPTH = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pida_pkg::dp_cmd_t  cmd,
    output pida_pkg::dp_stat_t      stat,
    input  wire logic [2:0]         command,
    input  wire logic [4:0]         position,
    input  wire logic signed [31:0] item_value,
    input  wire logic               m_tready,
    output logic                    m_tvalid,
    output logic signed [31:0]      element,
    output logic [4:0]              element_index,
    output logic [4:0]              length,
    output logic [1:0]              status,
    output logic                    last
);
    import pida_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = (CW > FieldWidth) ? CW : FieldWidth;

    logic signed [ElemWidth-1:0] cells_reg [DEPTH];
    logic signed [ElemWidth-1:0] cells_next [DEPTH];
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [IW-1:0]               disp_idx_reg;
    logic [IW-1:0]               disp_idx_next;
    logic                        m_tvalid_reg;
    logic signed [ElemWidth-1:0] elem_reg;
    logic [FieldWidth-1:0]       idx_reg;
    logic [FieldWidth-1:0]       len_reg;
    logic [1:0]                  status_reg;
    logic                        last_reg;

    logic                        load;
    logic signed [ElemWidth-1:0] o_elem;
    logic [FieldWidth-1:0]       o_idx;
    logic [1:0]                  o_status;
    logic                        o_last;
    logic [PW-1:0]               pos_ext;
    logic [PW-1:0]               count_ext;
    logic [PW-1:0]               count_next_ext;
    logic [PW-1:0]               disp_ext;
    logic [IW-1:0]               pos_idx;
    logic                        full;
    logic                        disp_last;

    assign pos_ext        = PW'(position);
    assign count_ext      = PW'(count_reg);
    assign count_next_ext = PW'(count_next);
    assign disp_ext       = PW'(disp_idx_reg);
    assign pos_idx        = pos_ext[IW-1:0];
    assign full           = (count_ext >= PW'(DEPTH));
    assign disp_last      = ((CW'(disp_idx_reg) + CW'(1)) == count_reg);

    assign stat.out_free   = !m_tvalid_reg || m_tready;
    assign stat.count_zero = (count_reg == '0);
    assign stat.disp_last  = disp_last;

    always_comb begin
        cells_next    = cells_reg;
        count_next    = count_reg;
        disp_idx_next = disp_idx_reg;
        load          = 1'b0;
        o_elem        = '0;
        o_idx         = '0;
        o_status      = STATUS_OK;
        o_last        = 1'b1;
        case (cmd.op)
            DP_EXEC: begin
                case (command)
                    CMD_CLEAR: begin
                        count_next = '0;
                        load       = 1'b1;
                    end
                    CMD_APPEND: begin
                        load   = 1'b1;
                        o_elem = item_value;
                        o_idx  = count_ext[FieldWidth-1:0];
                        if (full) begin
                            o_status = STATUS_FULL;
                        end else begin
                            cells_next[count_reg[IW-1:0]] = item_value;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_DISPLAY: begin
                        if (count_reg == '0) begin
                            load     = 1'b1;
                            o_status = STATUS_EMPTY;
                        end else begin
                            disp_idx_next = '0;
                        end
                    end
                    CMD_INSERT: begin
                        load   = 1'b1;
                        o_elem = item_value;
                        o_idx  = position;
                        if (pos_ext > count_ext) begin
                            o_status = STATUS_BAD;
                        end else if (full) begin
                            o_status = STATUS_FULL;
                        end else begin
                            for (int i = 1; i < DEPTH; i++) begin
                                if (PW'(i) > pos_ext && PW'(i) <= count_ext) begin
                                    cells_next[i] = cells_reg[i-1];
                                end
                            end
                            cells_next[pos_idx] = item_value;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    CMD_DELETE: begin
                        load  = 1'b1;
                        o_idx = position;
                        if (count_reg == '0) begin
                            o_status = STATUS_EMPTY;
                        end else if (pos_ext >= count_ext) begin
                            o_status = STATUS_BAD;
                        end else begin
                            o_elem = cells_reg[pos_idx];
                            for (int i = 0; i < DEPTH - 1; i++) begin
                                if (PW'(i) >= pos_ext && (PW'(i) + PW'(1)) < count_ext) begin
                                    cells_next[i] = cells_reg[i+1];
                                end
                            end
                            count_next = count_reg - CW'(1);
                        end
                    end
                    default: begin
                        load = 1'b0;
                    end
                endcase
            end
            DP_DISP_STEP: begin
                load          = 1'b1;
                o_elem        = cells_reg[disp_idx_reg];
                o_idx         = disp_ext[FieldWidth-1:0];
                o_last        = disp_last;
                disp_idx_next = disp_idx_reg + IW'(1);
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cells_reg    <= cells_next;
        disp_idx_reg <= disp_idx_next;
        if (load) begin
            elem_reg   <= o_elem;
            idx_reg    <= o_idx;
            len_reg    <= count_next_ext[FieldWidth-1:0];
            status_reg <= o_status;
            last_reg   <= o_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign element       = elem_reg;
    assign element_index = idx_reg;
    assign length        = len_reg;
    assign status        = status_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

// ----- sv/positional_insert_delete_array_core.sv -----
// Positional insert/delete array, top level: stream ports around the
// controller and datapath. Depends on pida_pkg, pida_ctrl, pida_dpath.
//
// Usage:
//   The slave channel takes one command item: s_tuser carries the command
//   (clear, append, display, insert, delete), s_tdata the position and value.
//   The master channel returns result items: element, index, length and
//   status in m_tdata, m_tlast set on the final result of a command.
//   Insert and delete shift the affected cells in parallel; every edit finishes
//   in the cycle it is accepted and loads its single result. An edit item is
//   taken each cycle while results are drained, so edits run at 1 item/cycle.
//   Display emits count results (one if the list is empty), one per cycle while
//   drained, from the element cells through the result register; no new item is
//   taken until its last result is loaded. Unused command codes are taken and
//   produce no result. A stalled receiver holds the result register and blocks
//   s_tready. Reset empties the list (count goes to zero) and drops any pending
//   result; element storage is not cleared and needs no startup time.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_array_core #(
    parameter int DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // position[4:0], item_value[36:5], zero pad
    input  wire logic [2:0]  s_tuser,   // command[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // element[31:0], element_index[36:32],
                                        // length[41:37], status[43:42], zero pad
    output logic             m_tlast
);
    import pida_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] element;
    logic [4:0]         element_index;
    logic [4:0]         length;
    logic [1:0]         status;

    pida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    pida_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .command       (s_tuser),
        .position      (s_tdata[4:0]),
        .item_value    (s_tdata[36:5]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .element       (element),
        .element_index (element_index),
        .length        (length),
        .status        (status),
        .last          (m_tlast)
    );

    assign m_tdata = {4'b0000, status, length, element_index, element};

endmodule

`default_nettype wire
